/* src/urc_pkg.sv */
// Shared types, widths, reset values and codes of the ultrasonic range controller.
package urc_pkg;

  localparam int CountWidthDefault = 17;
  localparam int TrigWidth         = 8;
  localparam int TimeoutWidth      = 17;
  localparam int ScaleWidth        = 12;
  localparam int StatusWidth       = 2;
  localparam int DistWidth         = 13;
  localparam int CfgIndexWidth     = 2;
  localparam int CfgDataWidth      = 17;
  localparam int ScaleShift        = 16;

  localparam logic [DistWidth-1:0] DistMax = '1;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] REG_TRIG_LOW     = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_TRIG_HIGH    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ECHO_TIMEOUT = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_CM_PER_TICK  = 2'd3;

  // Reset values of the registers.
  localparam logic [TrigWidth-1:0]    TrigLowReset     = 8'd2;
  localparam logic [TrigWidth-1:0]    TrigHighReset    = 8'd10;
  localparam logic [TimeoutWidth-1:0] EchoTimeoutReset = 17'd100000;
  localparam logic [ScaleWidth-1:0]   CmPerTickReset   = 12'd1114;

  // Measurement status codes.
  localparam logic [StatusWidth-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_NO_ECHO = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_STUCK   = 2'd2;

  typedef struct packed {
    logic [TrigWidth-1:0]    trig_low_ticks;
    logic [TrigWidth-1:0]    trig_high_ticks;
    logic [TimeoutWidth-1:0] echo_timeout_ticks;
    logic [ScaleWidth-1:0]   cm_per_tick_q16;
  } cfg_t;

  typedef struct packed {
    logic                   trig_level;
    logic                   busy_res;
    logic                   done_res;
    logic [StatusWidth-1:0] status;
    logic [DistWidth-1:0]   range_cm;
  } res_t;

endpackage

/* src/urc_if.sv */
// Request channel interfaces for ticks and results of the ultrasonic range controller.
interface urc_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface urc_result_if;
  import urc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   trig_level;
  logic                   busy_res;
  logic                   done_res;
  logic [StatusWidth-1:0] status;
  logic [DistWidth-1:0]   range_cm;

  modport source (output valid, output trig_level, output busy_res, output done_res,
                  output status, output range_cm, input ready);
  modport sink (input valid, input trig_level, input busy_res, input done_res,
                input status, input range_cm, output ready);
endinterface

/* src/urc_seq.sv */
// Measurement sequencer: phase machine, tick counter and distance accumulator.
module urc_seq #(
  parameter int CountWidth = urc_pkg::CountWidthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          start_req,
  input  logic          echo_level,
  input  urc_pkg::cfg_t cfg,
  output urc_pkg::res_t res
);
  import urc_pkg::*;

  localparam int AccWidth = CountWidth + ScaleWidth;
  localparam int LimWidth = (CountWidth > TimeoutWidth) ? CountWidth : TimeoutWidth;
  localparam logic [CountWidth-1:0] CntMax = '1;
  localparam logic [CountWidth-1:0] CntOne = CountWidth'(1);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_TLOW  = 5'b00010,
    PH_THIGH = 5'b00100,
    PH_WAIT  = 5'b01000,
    PH_ECHO  = 5'b10000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [CountWidth-1:0]  tick_count, tick_count_next;
  logic [AccWidth-1:0]    acc, acc_next;
  logic [DistWidth-1:0]   last_distance, last_distance_next;
  logic [StatusWidth-1:0] last_status, last_status_next;

  logic                  done;
  logic [CountWidth:0]   count_inc;
  logic [CountWidth-1:0] hi;
  logic [LimWidth-1:0]   timeout_ext;
  logic [CountWidth-1:0] lim;
  logic [AccWidth-1:0]   dist_full;
  logic [DistWidth-1:0]  dist_sat;

  // Effective pulse length and echo limit after the zero and clipping rules.
  always_comb begin
    hi = (cfg.trig_high_ticks == '0) ? CntOne : CountWidth'(cfg.trig_high_ticks);
    timeout_ext = LimWidth'(cfg.echo_timeout_ticks);
    if (timeout_ext == '0) begin
      lim = CntOne;
    end else if (timeout_ext > LimWidth'(CntMax)) begin
      lim = CntMax;
    end else begin
      lim = timeout_ext[CountWidth-1:0];
    end
  end

  // The accumulator already holds ticks times scale, so the distance is a shift.
  always_comb begin
    dist_full = acc >> ScaleShift;
    dist_sat  = (dist_full > AccWidth'(DistMax)) ? DistMax : dist_full[DistWidth-1:0];
  end

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    acc_next           = acc;
    last_distance_next = last_distance;
    last_status_next   = last_status;
    done               = 1'b0;
    count_inc          = {1'b0, tick_count} + (CountWidth + 1)'(1);

    case (phase)
      PH_TLOW: begin
        if (tick_count >= CountWidth'(cfg.trig_low_ticks)) begin
          phase_next      = PH_THIGH;
          tick_count_next = CntOne;
        end else begin
          tick_count_next = count_inc[CountWidth-1:0];
        end
      end
      PH_THIGH: begin
        if (tick_count >= hi) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc[CountWidth-1:0];
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          phase_next      = PH_ECHO;
          tick_count_next = CntOne;
          acc_next        = AccWidth'(cfg.cm_per_tick_q16);
          // A limit of one tick is already reached by the first high tick.
          if (CntOne >= lim) begin
            phase_next         = PH_IDLE;
            tick_count_next    = '0;
            last_status_next   = STATUS_STUCK;
            last_distance_next = '0;
            done               = 1'b1;
          end
        end else begin
          tick_count_next = count_inc[CountWidth-1:0];
          if (count_inc >= {1'b0, lim}) begin
            phase_next         = PH_IDLE;
            tick_count_next    = '0;
            last_status_next   = STATUS_NO_ECHO;
            last_distance_next = '0;
            done               = 1'b1;
          end
        end
      end
      PH_ECHO: begin
        if (echo_level) begin
          tick_count_next = count_inc[CountWidth-1:0];
          acc_next        = acc + AccWidth'(cfg.cm_per_tick_q16);
          if (count_inc >= {1'b0, lim}) begin
            phase_next         = PH_IDLE;
            tick_count_next    = '0;
            last_status_next   = STATUS_STUCK;
            last_distance_next = '0;
            done               = 1'b1;
          end
        end else begin
          phase_next         = PH_IDLE;
          tick_count_next    = '0;
          last_status_next   = STATUS_OK;
          last_distance_next = dist_sat;
          done               = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          phase_next      = (cfg.trig_low_ticks == '0) ? PH_THIGH : PH_TLOW;
          tick_count_next = CntOne;
        end
      end
    endcase
  end

  always_comb begin
    res.trig_level = (phase_next == PH_THIGH);
    res.busy_res   = (phase_next != PH_IDLE);
    res.done_res   = done;
    res.status     = last_status_next;
    res.range_cm   = last_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      last_distance <= '0;
      last_status   <= STATUS_OK;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      last_distance <= last_distance_next;
      last_status   <= last_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc <= acc_next;
    end
  end

endmodule

/* src/ultrasonic_range_controller_core.sv */
// Top level of the ultrasonic range controller: registers, handshake and result register.
// An accepted tick request has its result captured in the result register as it is taken.
// Throughput: one tick request per cycle; the single result register limits the rate
// only while the result side holds ready low.
// Reset (rst, synchronous, active high) sets the phase to idle, clears the tick count,
// the last status and distance, empties the result register and restores register defaults.
module ultrasonic_range_controller_core #(
  parameter int CountWidth = urc_pkg::CountWidthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  urc_tick_if.sink                          tick,
  urc_result_if.source                      result,
  input  logic                              cfg_wr_en,
  input  logic [urc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [urc_pkg::CfgDataWidth-1:0]  cfg_data
);
  import urc_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_hold;
  logic accept;
  logic result_valid;

  // Configuration registers. The user must write them only while no measurement is running,
  // so the sequencer sees stable values throughout; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trig_low_ticks     <= TrigLowReset;
      cfg.trig_high_ticks    <= TrigHighReset;
      cfg.echo_timeout_ticks <= EchoTimeoutReset;
      cfg.cm_per_tick_q16    <= CmPerTickReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRIG_LOW:     cfg.trig_low_ticks     <= cfg_data[TrigWidth-1:0];
        REG_TRIG_HIGH:    cfg.trig_high_ticks    <= cfg_data[TrigWidth-1:0];
        REG_ECHO_TIMEOUT: cfg.echo_timeout_ticks <= cfg_data[TimeoutWidth-1:0];
        REG_CM_PER_TICK:  cfg.cm_per_tick_q16    <= cfg_data[ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  // A new tick is taken whenever the result register is empty or is being
  // emptied in the same cycle, so back-to-back ticks flow at full rate while result.ready is high.
  assign tick.ready = !result_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  // The sequencer advances its state only on an accepted tick and presents
  // the result of that tick combinationally for capture below.
  urc_seq #(
    .CountWidth(CountWidth)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .start_req  (tick.start_req),
    .echo_level (tick.echo_level),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register: the valid flag is control state, the payload is not reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hold <= res;
    end
  end

  assign result.valid      = result_valid;
  assign result.trig_level = res_hold.trig_level;
  assign result.busy_res   = res_hold.busy_res;
  assign result.done_res   = res_hold.done_res;
  assign result.status     = res_hold.status;
  assign result.range_cm   = res_hold.range_cm;

endmodule

/* src/urc_checker.sv */
// Port-level checker for the ultrasonic range controller and its bind.
module urc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          tick_valid,
  input logic                          tick_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          trig_level,
  input logic                          busy_res,
  input logic                          done_res,
  input logic [urc_pkg::StatusWidth-1:0] status,
  input logic [urc_pkg::DistWidth-1:0]   range_cm
);
  import urc_pkg::*;

  // A result that waits must keep its contents.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable(trig_level) && $stable(busy_res) && $stable(done_res) &&
      $stable(status) && $stable(range_cm))
    else $error("stalled result changed");

  // Every accepted tick request yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> result_valid)
    else $error("accepted tick produced no result");

  // No tick is taken while a result is blocked, so none is overwritten.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !tick_ready)
    else $error("tick accepted over a blocked result");

  // Reset leaves the result register empty.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind ultrasonic_range_controller_core urc_checker u_urc_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .trig_level   (result.trig_level),
  .busy_res     (result.busy_res),
  .done_res     (result.done_res),
  .status       (result.status),
  .range_cm     (result.range_cm)
);

/* tb/urc_range_checker.sv */
// Checker of the ultrasonic range controller: tracks tick requests, predicts results, compares.
module urc_range_checker (
  input  logic                              clk,
  input  logic                              rst,
  urc_tick_if                               tick,
  urc_result_if                             result,
  input  logic                              cfg_wr_en,
  input  logic [urc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [urc_pkg::CfgDataWidth-1:0]  cfg_data,
  output int unsigned                       fail_count,
  output int unsigned                       awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import urc_pkg::*;

  localparam int CountW = CountWidthDefault;

  typedef enum logic [4:0] {
    RP_IDLE      = 5'b00001,
    RP_TRIG_LOW  = 5'b00010,
    RP_TRIG_HIGH = 5'b00100,
    RP_ECHO_WAIT = 5'b01000,
    RP_ECHO_HIGH = 5'b10000
  } ranging_phase_t;

  cfg_t              regs;
  ranging_phase_t    phase;
  logic [CountW-1:0] count;
  logic [DistWidth-1:0]   last_dist;
  logic [StatusWidth-1:0] last_status;
  res_t              ranging_results[$];
  res_t              want;

  initial begin
    fail_count = 0;
    awaited = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic close_measurement(input logic [StatusWidth-1:0] st,
                                   input logic [DistWidth-1:0] range_in);
    last_status = st;
    last_dist = range_in;
    phase = RP_IDLE;
    count = '0;
  endtask

  // One tick of the ranging sequence; the result shows the state after the tick.
  task automatic step_ranging(input logic start, input logic echo);
    logic [TimeoutWidth-1:0]          limit;
    logic [TrigWidth-1:0]             high_len;
    logic [CountW+ScaleWidth-1:0]     product;
    logic [CountW+ScaleWidth-1:0]     range_val;
    logic                             finished;
    res_t                             r;
    high_len = (regs.trig_high_ticks == '0) ? TrigWidth'(1) : regs.trig_high_ticks;
    limit = (regs.echo_timeout_ticks == '0) ? TimeoutWidth'(1) : regs.echo_timeout_ticks;
    finished = 1'b0;
    case (phase)
      RP_TRIG_LOW: begin
        if (count >= regs.trig_low_ticks) begin
          phase = RP_TRIG_HIGH;
          count = CountW'(1);
        end else begin
          count = count + 1'b1;
        end
      end
      RP_TRIG_HIGH: begin
        if (count >= high_len) begin
          phase = RP_ECHO_WAIT;
          count = '0;
        end else begin
          count = count + 1'b1;
        end
      end
      RP_ECHO_WAIT: begin
        if (echo) begin
          phase = RP_ECHO_HIGH;
          count = CountW'(1);
          if (count >= limit) begin
            close_measurement(STATUS_STUCK, '0);
            finished = 1'b1;
          end
        end else begin
          count = count + 1'b1;
          if (count >= limit) begin
            close_measurement(STATUS_NO_ECHO, '0);
            finished = 1'b1;
          end
        end
      end
      RP_ECHO_HIGH: begin
        if (echo) begin
          count = count + 1'b1;
          if (count >= limit) begin
            close_measurement(STATUS_STUCK, '0);
            finished = 1'b1;
          end
        end else begin
          product = count * regs.cm_per_tick_q16;
          range_val = product >> ScaleShift;
          if (range_val > DistMax) range_val = DistMax;
          close_measurement(STATUS_OK, range_val[DistWidth-1:0]);
          finished = 1'b1;
        end
      end
      default: begin
        phase = RP_IDLE;
        if (start) begin
          phase = (regs.trig_low_ticks == '0) ? RP_TRIG_HIGH : RP_TRIG_LOW;
          count = CountW'(1);
        end
      end
    endcase
    r.trig_level = (phase == RP_TRIG_HIGH);
    r.busy_res = (phase != RP_IDLE);
    r.done_res = finished;
    r.status = last_status;
    r.range_cm = last_dist;
    ranging_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs = '{TrigLowReset, TrigHighReset, EchoTimeoutReset, CmPerTickReset};
      phase = RP_IDLE;
      count = '0;
      last_dist = '0;
      last_status = STATUS_OK;
      ranging_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TRIG_LOW:     regs.trig_low_ticks = cfg_data[TrigWidth-1:0];
          REG_TRIG_HIGH:    regs.trig_high_ticks = cfg_data[TrigWidth-1:0];
          REG_ECHO_TIMEOUT: regs.echo_timeout_ticks = cfg_data[TimeoutWidth-1:0];
          REG_CM_PER_TICK:  regs.cm_per_tick_q16 = cfg_data[ScaleWidth-1:0];
          default: ;
        endcase
      end
      // A result always belongs to a tick accepted at an earlier edge, so compare first.
      if (result.valid && result.ready) begin
        if (ranging_results.size() == 0) begin
          report_mismatch("result request arrived with no tick result waiting");
        end else begin
          want = ranging_results.pop_front();
          if (result.trig_level !== want.trig_level)
            report_mismatch($sformatf("trig_level got %0d expected %0d",
                                      result.trig_level, want.trig_level));
          if (result.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res got %0d expected %0d",
                                      result.busy_res, want.busy_res));
          if (result.done_res !== want.done_res)
            report_mismatch($sformatf("done_res got %0d expected %0d",
                                      result.done_res, want.done_res));
          if (result.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      result.status, want.status));
          if (result.range_cm !== want.range_cm)
            report_mismatch($sformatf("range_cm got %0d expected %0d",
                                      result.range_cm, want.range_cm));
        end
      end
      if (tick.valid && tick.ready) step_ranging(tick.start_req, tick.echo_level);
    end
    awaited = ranging_results.size();
  end

endmodule

/* tb/ultrasonic_range_controller_core_test.sv */
// Testbench top of the ultrasonic range controller: clock, reset, stimulus and verdict.
module ultrasonic_range_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import urc_pkg::*;

  // The block never stays silent for long when it is fed; anything past this is a hang.
  localparam int unsigned WatchdogLimit = 400;
  // Random tick requests wanted after the directed part.
  localparam int unsigned RandomTicks = 1050;
  // The tail of the run in which neither side idles.
  localparam int unsigned QuietTicks = 150;

  logic clk = 1'b0;
  logic rst;
  logic                     cfg_wr_en;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  urc_tick_if   tick_ch();
  urc_result_if res_ch();

  int unsigned fail_count;
  int unsigned awaited;

  // Bookkeeping of accepted requests on both channels, updated at the rising edge.
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned silent_cycles;
  logic        last_busy;

  // Idling controls: each side idles only while its flag is set and the tail is not reached.
  logic        src_idle_on;
  logic        sink_idle_on;
  logic        quiet;
  int unsigned stall_left;

  // The stimulus keeps its own view of the registers only to shape well-formed sequences.
  logic [TrigWidth-1:0]    cur_low;
  logic [TrigWidth-1:0]    cur_high;
  logic [TimeoutWidth-1:0] cur_timeout;

  always #2 clk = ~clk;

  ultrasonic_range_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  urc_range_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick_ch),
    .result     (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // Count accepted requests and watch for a hang: a cycle with no request accepted on
  // either channel adds to the silent count, and too many in a row ends the run.
  always @(posedge clk) begin
    if (rst) begin
      ticks_sent <= 0;
      results_seen <= 0;
      silent_cycles <= 0;
      last_busy <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) ticks_sent <= ticks_sent + 1;
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        last_busy <= res_ch.busy_res;
      end
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        silent_cycles <= 0;
      end else if (silent_cycles >= WatchdogLimit) begin
        $display("timeout: no request accepted for %0d cycles", silent_cycles);
        $display("ultrasonic_range_controller_core_test NOT OK");
        $finish;
      end else begin
        silent_cycles <= silent_cycles + 1;
      end
    end
  end

  // The result side stalls in bursts while its idling is enabled and the quiet tail is not reached.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_ch.ready = 1'b0;
      stall_left--;
    end else if (sink_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      res_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  // Offer one tick request, possibly after an idle burst, and hold it until accepted.
  // Valid drops at the following falling edge unless the next call raises it again.
  task automatic send_tick(input logic start, input logic echo);
    if (src_idle_on && !quiet && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    tick_ch.start_req = start;
    tick_ch.echo_level = echo;
    tick_ch.valid = 1'b1;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
    tick_ch.valid = 1'b0;
  endtask

  // A tick inside a measurement: the start request is random and should be ignored.
  task automatic busy_tick(input logic echo);
    send_tick($urandom_range(0, 3) == 0, echo);
  endtask

  task automatic wait_results();
    while (results_seen != ticks_sent) @(negedge clk);
  endtask

  // Pause until every result is in, then bring the block back to idle. Alternating echo
  // levels finish any phase: a rise leaves the echo wait and a fall ends the echo pulse.
  task automatic settle();
    logic echo;
    echo = 1'b1;
    wait_results();
    while (last_busy) begin
      send_tick(1'b0, echo);
      echo = ~echo;
      wait_results();
    end
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Write all four registers; the bits above each register's width carry junk that the
  // block has to drop.
  task automatic program_config(input logic [TrigWidth-1:0] low,
                                input logic [TrigWidth-1:0] high,
                                input logic [TimeoutWidth-1:0] timeout,
                                input logic [ScaleWidth-1:0] scale);
    logic [CfgDataWidth-1:0] junk;
    junk = CfgDataWidth'($urandom);
    write_reg(REG_TRIG_LOW, {junk[CfgDataWidth-1:TrigWidth], low});
    junk = CfgDataWidth'($urandom);
    write_reg(REG_TRIG_HIGH, {junk[CfgDataWidth-1:TrigWidth], high});
    write_reg(REG_ECHO_TIMEOUT, timeout);
    junk = CfgDataWidth'($urandom);
    write_reg(REG_CM_PER_TICK, {junk[CfgDataWidth-1:ScaleWidth], scale});
    cur_low = low;
    cur_high = high;
    cur_timeout = timeout;
  endtask

  // One well-formed measurement with random content: the start, the trigger ticks, then
  // either an echo pulse, a missing echo or an echo stuck high. Long limits are only used
  // with echo pulses, since waiting them out would take the whole run.
  task automatic run_measurement();
    int unsigned limit;
    int unsigned span;
    int unsigned kind;
    int unsigned wait_len;
    int unsigned high_cap;
    limit = (cur_timeout == 0) ? 1 : cur_timeout;
    span = cur_low + ((cur_high == 0) ? 1 : cur_high);
    kind = $urandom_range(0, 9);
    if (limit > 400) kind = 0;
    wait_len = $urandom_range(0, (limit > 30) ? 30 : limit - 1);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    // The echo level is of no interest while the trigger is driven.
    repeat (span) busy_tick(1'($urandom_range(0, 1)));
    if (kind <= 6) begin
      high_cap = ($urandom_range(0, 9) == 0) ? 400 : 80;
      if (high_cap > limit - 1) high_cap = limit - 1;
      if (high_cap == 0) high_cap = 1;
      repeat (wait_len) busy_tick(1'b0);
      repeat ($urandom_range(1, high_cap)) busy_tick(1'b1);
      // The falling echo ends the measurement; a start on that tick must not be taken.
      send_tick(1'($urandom_range(0, 1)), 1'b0);
    end else if (kind <= 8) begin
      repeat (limit - 1) busy_tick(1'b0);
      send_tick(1'($urandom_range(0, 1)), 1'b0);
    end else begin
      repeat (wait_len) busy_tick(1'b0);
      repeat (limit - 1) busy_tick(1'b1);
      send_tick(1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase_no;
    int unsigned measurements;
    logic [TimeoutWidth-1:0] timeout;
    logic [ScaleWidth-1:0]   scale;

    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.start_req = 1'b0;
    tick_ch.echo_level = 1'b0;
    res_ch.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_TRIG_LOW;
    cfg_data = '0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    quiet = 1'b0;
    stall_left = 0;
    cur_low = TrigLowReset;
    cur_high = TrigHighReset;
    cur_timeout = EchoTimeoutReset;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed part. With the reset settings, a start followed by a start while busy;
    // the settle pass then runs the measurement to a short echo pulse.
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();

    // Zero low time, zero high time and zero timeout: the start goes straight to the
    // high trigger tick, a rising echo is stuck at once, and a low echo times out at once.
    program_config('0, '0, '0, 12'd4095);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();

    // Shortest trigger with a short echo pulse that completes within the limit.
    program_config(8'd1, 8'd1, 17'd4, 12'd4095);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle();

    // Random part, phase by phase. The first two phases use the register extremes; the
    // rest draw settings at random. Every phase ends with the sender waiting for every
    // result and the block back at idle, which is when the registers may change.
    target = ticks_sent + RandomTicks;
    phase_no = 0;
    while (ticks_sent < target) begin
      if (ticks_sent + QuietTicks >= target) quiet = 1'b1;
      case (phase_no)
        0: program_config(8'd255, 8'd255, 17'd131071, 12'd4095);
        1: program_config(8'd0, 8'd1, 17'd1, 12'd0);
        default: begin
          case ($urandom_range(0, 3))
            0: timeout = TimeoutWidth'($urandom_range(1, 12));
            1: timeout = TimeoutWidth'($urandom_range(13, 400));
            2: timeout = TimeoutWidth'($urandom_range(401, 131071));
            default: timeout = EchoTimeoutReset;
          endcase
          case ($urandom_range(0, 5))
            0: scale = '0;
            1: scale = '1;
            default: scale = ScaleWidth'($urandom_range(0, 4095));
          endcase
          program_config(TrigWidth'($urandom_range(0, 8)), TrigWidth'($urandom_range(0, 16)),
                         timeout, scale);
        end
      endcase
      // Some phases idle on one side, some on both, some on neither.
      src_idle_on = ($urandom_range(0, 2) != 0);
      sink_idle_on = ($urandom_range(0, 2) != 0);
      measurements = (phase_no == 0) ? 1 : $urandom_range(2, 5);
      repeat (measurements) begin
        if (ticks_sent < target) begin
          if (ticks_sent + QuietTicks >= target) quiet = 1'b1;
          run_measurement();
          // Stray ticks between measurements; a rare start here opens a broken sequence.
          repeat ($urandom_range(0, 4))
            send_tick($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
        end
      end
      settle();
      phase_no++;
    end

    // Wait for every result, then keep watching to catch any extra result before the verdict.
    wait_results();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("ultrasonic_range_controller_core_test OK");
    end else begin
      if (awaited != 0) $display("%0d expected results never arrived", awaited);
      $display("ultrasonic_range_controller_core_test NOT OK");
    end
    $finish;
  end

endmodule
